// ===== sv/kwq_pkg.sv =====
// kwq_pkg: sizes, item types, opcodes, status codes and the key compare
// shared by the keyed waiting queue cells and its top level.
// no dependencies.
`timescale 1ns / 1ps

package kwq_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_CHARS = 8;
	localparam int KEY_W     = 64;
	localparam int HANDLE_W  = 16;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// opcodes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle_in;
	} kwq_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic                found;
		logic [HANDLE_W-1:0] handle_out;
	} kwq_rsp_t;

	// contents of one cell
	typedef struct packed {
		logic                valid;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} kwq_entry_t;

	// per-cell controls from the sequencer
	typedef struct packed {
		logic cmp_en;
		logic append_en;
		logic shift_en;
	} kwq_cell_ctl_t;

	// string compare over the low KEY_CHARS bytes: every byte must agree
	// unless an earlier byte already agreed on the terminating zero
	function automatic logic key_match(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		logic ok;
		logic term;
		logic eq;
		ok   = 1'b1;
		term = 1'b0;
		for (int i = 0; i < KEY_CHARS; i++) begin
			eq = (a[8*i +: 8] == b[8*i +: 8]);
			if (!eq && !term) begin
				ok = 1'b0;
			end
			if (eq && (a[8*i +: 8] == 8'd0)) begin
				term = 1'b1;
			end
		end
		return ok;
	endfunction

endpackage

// ===== sv/kwq_cell.sv =====
// kwq_cell: one slot of the waiting queue; holds an entry, compares it
// against the request key and takes its neighbor's entry when the gap closes.
// depends on kwq_pkg.
`timescale 1ns / 1ps

module kwq_cell import kwq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  kwq_cell_ctl_t       ctl,
	input  logic [KEY_W-1:0]    req_key,
	input  logic [HANDLE_W-1:0] req_handle,
	input  kwq_entry_t          next,
	output kwq_entry_t          entry,
	output logic                hit
);

	logic                valid_q;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                hit_q;

	// valid bit and registered match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.append_en) begin
				valid_q <= 1'b1;
			end else if (ctl.shift_en) begin
				valid_q <= next.valid;
			end
			if (ctl.cmp_en) begin
				hit_q <= valid_q && key_match(key_q, req_key);
			end
		end
	end

	// stored key and handle
	always_ff @(posedge clk) begin
		if (ctl.append_en) begin
			key_q    <= req_key;
			handle_q <= req_handle;
		end else if (ctl.shift_en) begin
			key_q    <= next.key;
			handle_q <= next.handle;
		end
	end

	assign entry.valid  = valid_q;
	assign entry.key    = key_q;
	assign entry.handle = handle_q;
	assign hit          = hit_q;

endmodule

// ===== sv/keyed_waiting_queue.sv =====
// keyed_waiting_queue: ordered queue of keyed entries in a row of cells,
// with append, query and remove-first-match. depends on kwq_pkg, kwq_cell.
// each item is accepted, then compared in every cell, then selected and shifted;
// its result is registered in the select step; the next item waits until select ends.
// a stalled result holds the select step and thus the next item.
// reset: queue empty, no result pending, ready for an item right after reset.
`timescale 1ns / 1ps

module keyed_waiting_queue import kwq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  kwq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output kwq_rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_MATCH = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t             state_q;
	kwq_req_t           req_q;
	logic [CNT_W-1:0]   occ_q;
	logic               rsp_valid_q;
	kwq_rsp_t           rsp_q;

	kwq_entry_t          entries [DEPTH];
	kwq_cell_ctl_t       ctls    [DEPTH];
	logic [DEPTH-1:0]    hit_vec;
	logic [DEPTH-1:0]    valid_vec;
	logic [DEPTH-1:0]    first_oh;
	logic [DEPTH-1:0]    shift_mask;
	logic [HANDLE_W-1:0] sel_handle;
	logic                any_hit;
	logic                is_full;
	logic                apply_go;
	logic                do_append;
	logic                do_remove;
	kwq_rsp_t            rsp_d;

	assign req_stall = (state_q != S_IDLE);
	assign apply_go  = (state_q == S_APPLY) && (!rsp_valid_q || !rsp_stall);
	assign is_full   = (occ_q == CNT_W'(DEPTH));
	assign any_hit   = |hit_vec;
	assign do_append = apply_go && (req_q.opcode == OP_APPEND) && !is_full;
	assign do_remove = apply_go && (req_q.opcode == OP_REMOVE) && any_hit;

	// first matching cell in queue order and every cell from it to the tail
	assign first_oh   = hit_vec & (~hit_vec + DEPTH'(1));
	assign shift_mask = ~(first_oh - DEPTH'(1));

	// handle of the first matching cell
	always_comb begin
		sel_handle = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_handle = sel_handle | (entries[i].handle & {HANDLE_W{first_oh[i]}});
		end
	end

	// row of cells, each fed by its successor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		kwq_entry_t nb;
		if (i == DEPTH - 1) begin : g_last
			assign nb = '0;
		end else begin : g_mid
			assign nb = entries[i+1];
		end
		assign ctls[i].cmp_en    = (state_q == S_MATCH);
		assign ctls[i].append_en = do_append && (occ_q == CNT_W'(i));
		assign ctls[i].shift_en  = do_remove && shift_mask[i];
		assign valid_vec[i]      = entries[i].valid;

		kwq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctls[i]),
			.req_key    (req_q.key),
			.req_handle (req_q.handle_in),
			.next       (nb),
			.entry      (entries[i]),
			.hit        (hit_vec[i])
		);
	end

	// result of the item in the select step
	always_comb begin
		rsp_d = '0;
		case (req_q.opcode)
			OP_APPEND: begin
				if (is_full) begin
					rsp_d.status = ST_FULL;
				end
			end
			OP_QUERY: begin
				rsp_d.found  = any_hit;
				rsp_d.status = any_hit ? ST_OK : ST_MISS;
			end
			OP_REMOVE: begin
				rsp_d.found      = any_hit;
				rsp_d.status     = any_hit ? ST_OK : ST_MISS;
				rsp_d.handle_out = any_hit ? sel_handle : '0;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// sequencer, occupancy and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (apply_go) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (do_append) begin
				occ_q <= occ_q + CNT_W'(1);
			end else if (do_remove) begin
				occ_q <= occ_q - CNT_W'(1);
			end
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_q <= req;
		end
		if (apply_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// occupancy stays within the queue size
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy beyond queue size");

	// valid cells agree with occupancy
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(occ_q))
		else $error("valid cells disagree with occupancy");

	// valid cells stay packed from the head
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + DEPTH'(1)) & valid_vec) == '0)
		else $error("gap in the queue");

	// a found result always carries status ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.found) |-> (rsp_q.status == ST_OK))
		else $error("found with bad status");

	// a removal shrinks the queue by one entry
	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		do_remove |=> (occ_q == $past(occ_q) - CNT_W'(1)))
		else $error("removal did not shrink queue");

endmodule
